FILE: hdl/bct_pkg.sv
// Shared constants and register codes for the bilinear cohesive traction pipeline.
package bct_pkg;

  localparam int SEP_FRAC  = 24;               // fraction bits of separations
  localparam int DMG_FRAC  = 24;               // fraction bits of damage
  localparam int DMG_W     = DMG_FRAC + 1;
  localparam int QBITS     = 2 * SEP_FRAC;     // quotient bits per divider
  localparam int DIV_W     = 96;               // divider operand / remainder width
  localparam int DIV_LAT   = QBITS + 1;        // divider stage count
  localparam int TS_SHIFT  = 16 + SEP_FRAC;    // traction slope product shift
  localparam int IN_W      = 192;
  localparam int OUT_W     = 544;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [DMG_W-1:0] DMG_ONE = DMG_W'(1) << DMG_FRAC;
  localparam logic [47:0] LIM47  = {1'b0, {47{1'b1}}};
  localparam logic [47:0] HALF48 = {1'b1, 47'd0};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STIFF = 3'd0,
    CFG_ONSET = 3'd1,
    CFG_FAIL  = 3'd2,
    CFG_PEN   = 3'd3,
    CFG_JAC   = 3'd4
  } cfg_idx_t;

endpackage

FILE: hdl/bct_pipe_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module bct_pipe_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bct_pkg::DIV_W-1:0]   num,
  input  logic [bct_pkg::DIV_W-1:0]   den,
  output logic [bct_pkg::QBITS-1:0]   quo,
  output logic                        ovf
);
  import bct_pkg::*;

  logic [DIV_W-1:0] rem_q    [DIV_LAT];
  logic [DIV_W-1:0] den_q    [DIV_LAT];
  logic [QBITS-1:0] quo_q    [DIV_LAT];
  logic             ovf_q    [DIV_LAT];
  logic [DIV_W-1:0] rem_next [DIV_LAT];
  logic [QBITS-1:0] quo_next [DIV_LAT];

  always_comb begin
    logic [DIV_W:0] shifted;
    rem_next[0] = num;
    quo_next[0] = '0;
    for (int i = 1; i < DIV_LAT; i++) begin
      shifted = {rem_q[i-1], 1'b0};
      if (shifted >= {1'b0, den_q[i-1]}) begin
        rem_next[i] = DIV_W'(shifted - {1'b0, den_q[i-1]});
        quo_next[i] = {quo_q[i-1][QBITS-2:0], 1'b1};
      end else begin
        rem_next[i] = shifted[DIV_W-1:0];
        quo_next[i] = {quo_q[i-1][QBITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= rem_next[0];
      den_q[0] <= den;
      quo_q[0] <= quo_next[0];
      ovf_q[0] <= (num >= den);
      for (int i = 1; i < DIV_LAT; i++) begin
        rem_q[i] <= rem_next[i];
        den_q[i] <= den_q[i-1];
        quo_q[i] <= quo_next[i];
        ovf_q[i] <= ovf_q[i-1];
      end
    end
  end

  assign quo = quo_q[DIV_LAT-1];
  assign ovf = ovf_q[DIV_LAT-1];

endmodule

FILE: hdl/bilinear_cohesive_traction.sv
// Top level: bilinear cohesive-zone traction-separation law, one material point per transaction.
// Pipeline: 5 front stages, 49 divider stages and 4 back stages; throughput one transaction
//   per cycle while the output is not stalled, set by the four bit-per-stage dividers that
//   run side by side.
// A stalled output holds the pipe only when the last internal stage is full; bubbles are squeezed out.
// Reset (synchronous, active high) clears valid bits and restores register defaults.
module bilinear_cohesive_traction (
  input  logic                            clk,
  input  logic                            rst,
  // input: [31:0] eff_sep, [63:32] normal_opening,
  // [95:64] norm_pen, [127:96] shear_jump_one, [159:128] shear_jump_two,
  // [184:160] previous_damage, rest zero
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bct_pkg::IN_W-1:0]        s_tdata,
  // output: [47:0] traction_normal, [95:48] traction_shear_one,
  // [143:96] traction_shear_two, [168:144] damage, [169] damage_held,
  // [201:170] active_stiffness, [249:202] damage_slope_separation,
  // [297:250] damage_slope_onset, [345:298] damage_slope_failure,
  // [409:346] traction_normal_slope, [473:410] traction_shear_one_slope,
  // [537:474] traction_shear_two_slope, rest zero
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bct_pkg::OUT_W-1:0]       m_tdata,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [bct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bct_pkg::CFG_W-1:0]       cfg_data
);
  import bct_pkg::*;

  // sideband carried alongside the dividers
  typedef struct packed {
    logic signed [31:0] jn;
    logic signed [31:0] js1;
    logic signed [31:0] js2;
    logic signed [31:0] pen;
    logic [63:0]        kjn;
    logic [63:0]        kj1;
    logic [63:0]        kj2;
    logic signed [63:0] kpen;
    logic [DMG_W-1:0]   dold;
    logic               below;  // separation under onset
    logic               sat;    // separation at or past failure
    logic               zero;   // separation is zero
    logic               mid;    // strictly between onset and failure
  } side_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write them only while the pipe is empty; the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic [31:0] k_reg;
  logic [30:0] onset_reg;
  logic [30:0] fail_reg;
  logic        pen_reg;
  logic        jac_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg     <= 32'd65536;
      onset_reg <= 31'd0;
      fail_reg  <= 31'd16777216;
      pen_reg   <= 1'b0;
      jac_reg   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STIFF: k_reg     <= cfg_data;
        CFG_ONSET: onset_reg <= cfg_data[30:0];
        CFG_FAIL:  fail_reg  <= cfg_data[30:0];
        CFG_PEN:   pen_reg   <= cfg_data[0];
        CFG_JAC:   jac_reg   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. The output register loads when empty or taken; every other
  // stage moves when the output loads or when the last internal stage is a bubble.
  // ---------------------------------------------------------------------------
  logic out_load;
  logic en;
  logic p3_v;

  assign out_load = !m_tvalid || m_tready;
  assign en       = out_load || !p3_v;
  assign s_tready = en;

  // ---------------------------------------------------------------------------
  // S0: input capture
  // ---------------------------------------------------------------------------
  logic               s0_v;
  logic [31:0]        s0_dm;
  logic signed [31:0] s0_jn, s0_pen, s0_js1, s0_js2;
  logic [DMG_W-1:0]   s0_dold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_dm   <= s_tdata[31:0];
      s0_jn   <= s_tdata[63:32];
      s0_pen  <= s_tdata[95:64];
      s0_js1  <= s_tdata[127:96];
      s0_js2  <= s_tdata[159:128];
      s0_dold <= s_tdata[184:160];
    end
  end

  // ---------------------------------------------------------------------------
  // S1: differences and region flags
  // ---------------------------------------------------------------------------
  logic signed [32:0] dm_x, di_x, df_x, mdi_x, c_x, fdm_x;
  side_t              side1;

  always_comb begin
    dm_x  = $signed({s0_dm[31], s0_dm});
    di_x  = $signed({2'b00, onset_reg});
    df_x  = $signed({2'b00, fail_reg});
    mdi_x = dm_x - di_x;
    c_x   = df_x - di_x;
    fdm_x = df_x - dm_x;
    side1       = '0;
    side1.jn    = s0_jn;
    side1.js1   = s0_js1;
    side1.js2   = s0_js2;
    side1.pen   = s0_pen;
    side1.dold  = (s0_dold > DMG_ONE) ? DMG_ONE : s0_dold;
    side1.below = (dm_x < di_x);
    side1.sat   = !(dm_x < di_x) && !(dm_x < df_x);
    side1.zero  = (s0_dm == 32'd0);
    side1.mid   = (dm_x > di_x) && (dm_x < df_x);
  end

  logic        s1_v;
  side_t       s1_sd;
  logic [31:0] s1_dm, s1_mdi, s1_c, s1_fdm;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sd  <= side1;
      s1_dm  <= s0_dm;
      s1_mdi <= mdi_x[31:0];
      s1_c   <= c_x[31:0];
      s1_fdm <= fdm_x[31:0];
    end
  end

  // ---------------------------------------------------------------------------
  // S2: first rank of 32x32 products
  // ---------------------------------------------------------------------------
  logic [31:0] jn_abs, js1_abs, js2_abs;
  side_t       side2;

  always_comb begin
    jn_abs  = s1_sd.jn[31]  ? 32'(-s1_sd.jn)  : s1_sd.jn;
    js1_abs = s1_sd.js1[31] ? 32'(-s1_sd.js1) : s1_sd.js1;
    js2_abs = s1_sd.js2[31] ? 32'(-s1_sd.js2) : s1_sd.js2;
    side2      = s1_sd;
    side2.kjn  = 64'(k_reg) * 64'(jn_abs);
    side2.kj1  = 64'(k_reg) * 64'(js1_abs);
    side2.kj2  = 64'(k_reg) * 64'(js2_abs);
    side2.kpen = 64'($signed({1'b0, k_reg}) * s1_sd.pen);
  end

  logic        s2_v;
  side_t       s2_sd;
  logic [31:0] s2_dm, s2_c;
  logic [63:0] s2_nt, s2_dt, s2_nm, s2_mm, s2_cc, s2_ni, s2_nf;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sd <= side2;
      s2_dm <= s1_dm;
      s2_c  <= s1_c;
      s2_nt <= 64'({1'b0, fail_reg}) * 64'(s1_mdi);   // trial numerator
      s2_dt <= 64'(s1_dm) * 64'(s1_c);                 // trial denominator
      s2_nm <= 64'({1'b0, fail_reg}) * 64'({1'b0, onset_reg});
      s2_mm <= 64'(s1_dm) * 64'(s1_dm);
      s2_cc <= 64'(s1_c) * 64'(s1_c);
      s2_ni <= 64'({1'b0, fail_reg}) * 64'(s1_fdm);
      s2_nf <= 64'({1'b0, onset_reg}) * 64'(s1_mdi);
    end
  end

  // ---------------------------------------------------------------------------
  // S3: partial products of the cubic denominators
  // ---------------------------------------------------------------------------
  logic        s3_v;
  side_t       s3_sd;
  logic [63:0] s3_nt, s3_dt, s3_nm, s3_ni, s3_nf;
  logic [63:0] s3_mmc_lo, s3_mmc_hi, s3_ccm_lo, s3_ccm_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sd     <= s2_sd;
      s3_nt     <= s2_nt;
      s3_dt     <= s2_dt;
      s3_nm     <= s2_nm;
      s3_ni     <= s2_ni;
      s3_nf     <= s2_nf;
      s3_mmc_lo <= 64'(s2_mm[31:0])  * 64'(s2_c);
      s3_mmc_hi <= 64'(s2_mm[63:32]) * 64'(s2_c);
      s3_ccm_lo <= 64'(s2_cc[31:0])  * 64'(s2_dm);
      s3_ccm_hi <= 64'(s2_cc[63:32]) * 64'(s2_dm);
    end
  end

  // ---------------------------------------------------------------------------
  // S4: combine partials into dm^2*c and dm*c^2
  // ---------------------------------------------------------------------------
  logic             s4_v;
  side_t            s4_sd;
  logic [63:0]      s4_nt, s4_dt, s4_nm, s4_ni, s4_nf;
  logic [DIV_W-1:0] s4_dmmc, s4_den2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sd   <= s3_sd;
      s4_nt   <= s3_nt;
      s4_dt   <= s3_dt;
      s4_nm   <= s3_nm;
      s4_ni   <= s3_ni;
      s4_nf   <= s3_nf;
      s4_dmmc <= {32'd0, s3_mmc_lo} + {s3_mmc_hi, 32'd0};
      s4_den2 <= {32'd0, s3_ccm_lo} + {s3_ccm_hi, 32'd0};
    end
  end

  // ---------------------------------------------------------------------------
  // Dividers: trial damage and the three damage slopes, in parallel.
  // The trial quotient carries extra bits; its top DMG_FRAC bits are the floor.
  // ---------------------------------------------------------------------------
  logic [QBITS-1:0] q_t, q_m, q_i, q_f;
  logic             ovf_t, ovf_m, ovf_i, ovf_f;

  bct_pipe_div u_div_trial (
    .clk (clk), .en (en),
    .num ({32'd0, s4_nt}), .den ({32'd0, s4_dt}),
    .quo (q_t), .ovf (ovf_t)
  );

  bct_pipe_div u_div_sep (
    .clk (clk), .en (en),
    .num ({32'd0, s4_nm}), .den (s4_dmmc),
    .quo (q_m), .ovf (ovf_m)
  );

  bct_pipe_div u_div_onset (
    .clk (clk), .en (en),
    .num ({32'd0, s4_ni}), .den (s4_den2),
    .quo (q_i), .ovf (ovf_i)
  );

  bct_pipe_div u_div_fail (
    .clk (clk), .en (en),
    .num ({32'd0, s4_nf}), .den (s4_den2),
    .quo (q_f), .ovf (ovf_f)
  );

  // delay line that matches the divider latency
  side_t              line_sd [DIV_LAT];
  logic [DIV_LAT-1:0] line_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_v <= '0;
    end else if (en) begin
      line_v <= {line_v[DIV_LAT-2:0], s4_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line_sd[0] <= s4_sd;
      for (int i = 1; i < DIV_LAT; i++) begin
        line_sd[i] <= line_sd[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // P1: trial damage, irreversibility cap, slope saturation
  // ---------------------------------------------------------------------------
  side_t            sd_end;
  logic [DMG_W-1:0] trial_div, trial, dmg1;
  logic             grew1;
  logic [46:0]      sm1;
  logic [47:0]      si1, sf1;

  always_comb begin
    sd_end    = line_sd[DIV_LAT-1];
    trial_div = ovf_t ? DMG_ONE : {1'b0, q_t[QBITS-1:QBITS-DMG_FRAC]};
    if (sd_end.below) begin
      trial = '0;
    end else if (sd_end.sat) begin
      trial = DMG_ONE;
    end else if (sd_end.zero) begin
      trial = '0;
    end else begin
      trial = trial_div;
    end
    grew1 = (trial > sd_end.dold);
    dmg1  = grew1 ? trial : sd_end.dold;
    sm1   = (ovf_m || (q_m > LIM47))  ? LIM47[46:0] : q_m[46:0];
    si1   = (ovf_i || (q_i > HALF48)) ? HALF48 : q_i;
    sf1   = (ovf_f || (q_f > HALF48)) ? HALF48 : q_f;
  end

  logic             p1_v;
  side_t            p1_sd;
  logic [DMG_W-1:0] p1_dmg;
  logic             p1_grew, p1_on;
  logic [46:0]      p1_sm;
  logic [47:0]      p1_si, p1_sf;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (en) begin
      p1_v <= line_v[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_sd   <= sd_end;
      p1_dmg  <= dmg1;
      p1_grew <= grew1;
      p1_on   <= jac_reg && grew1 && sd_end.mid;
      p1_sm   <= sm1;
      p1_si   <= si1;
      p1_sf   <= sf1;
    end
  end

  // ---------------------------------------------------------------------------
  // P2: active stiffness and partial products of K*|jump|*slope
  // ---------------------------------------------------------------------------
  logic [56:0] act_full;
  logic [63:0] kj [3];

  always_comb begin
    act_full = 57'(k_reg) * 57'(DMG_ONE - p1_dmg);
    kj[0] = p1_sd.kjn;
    kj[1] = p1_sd.kj1;
    kj[2] = p1_sd.kj2;
  end

  logic             p2_v;
  side_t            p2_sd;
  logic [DMG_W-1:0] p2_dmg;
  logic             p2_held, p2_on;
  logic [31:0]      p2_act;
  logic [46:0]      p2_sm;
  logic [47:0]      p2_si, p2_sf;
  logic [63:0]      p2_ll [3];
  logic [63:0]      p2_hl [3];
  logic [46:0]      p2_lh [3];
  logic [46:0]      p2_hh [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else if (en) begin
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_sd   <= p1_sd;
      p2_dmg  <= p1_dmg;
      p2_held <= jac_reg && !p1_grew;
      p2_on   <= p1_on;
      p2_act  <= act_full[DMG_FRAC+31:DMG_FRAC];
      p2_sm   <= p1_sm;
      p2_si   <= p1_si;
      p2_sf   <= p1_sf;
      for (int j = 0; j < 3; j++) begin
        p2_ll[j] <= 64'(kj[j][31:0])  * 64'(p1_sm[31:0]);
        p2_hl[j] <= 64'(kj[j][63:32]) * 64'(p1_sm[31:0]);
        p2_lh[j] <= 47'(kj[j][31:0])  * 47'(p1_sm[46:32]);
        p2_hh[j] <= 47'(kj[j][63:32]) * 47'(p1_sm[46:32]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // P3: traction products and full slope products
  // ---------------------------------------------------------------------------
  logic signed [31:0] jump2 [3];

  always_comb begin
    jump2[0] = p2_sd.jn;
    jump2[1] = p2_sd.js1;
    jump2[2] = p2_sd.js2;
  end

  side_t              p3_sd;
  logic [DMG_W-1:0]   p3_dmg;
  logic               p3_held, p3_on;
  logic [31:0]        p3_act;
  logic [46:0]        p3_sm;
  logic [47:0]        p3_si, p3_sf;
  logic signed [64:0] p3_tp [3];
  logic [111:0]       p3_sp [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_v <= 1'b0;
    end else if (en) begin
      p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_sd   <= p2_sd;
      p3_dmg  <= p2_dmg;
      p3_held <= p2_held;
      p3_on   <= p2_on;
      p3_act  <= p2_act;
      p3_sm   <= p2_sm;
      p3_si   <= p2_si;
      p3_sf   <= p2_sf;
      for (int j = 0; j < 3; j++) begin
        p3_tp[j] <= $signed({1'b0, p2_act}) * jump2[j];
        p3_sp[j] <= {48'd0, p2_ll[j]} + {16'd0, p2_hl[j], 32'd0}
                  + {33'd0, p2_lh[j], 32'd0} + {1'b0, p2_hh[j], 64'd0};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // P4: shift, sum, saturate; output register
  // ---------------------------------------------------------------------------
  function automatic logic [47:0] sat48(input logic signed [65:0] v);
    logic [47:0] r;
    if (v > $signed({19'd0, LIM47[46:0]})) begin
      r = LIM47;
    end else if (v < -$signed({18'd0, HALF48})) begin
      r = HALF48;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  // -K*jump*slope: the sign is the opposite of the jump's
  function automatic logic [63:0] tslope(input logic [111:0] p, input logic neg);
    logic [111:0] sh;
    logic [63:0]  lim, mag;
    sh  = p >> TS_SHIFT;
    lim = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    mag = (sh > {48'd0, lim}) ? lim : sh[63:0];
    return neg ? 64'(-mag) : mag;
  endfunction

  logic signed [65:0] pen_term;
  logic signed [65:0] tsum [3];
  logic               neg_j [3];
  logic               ts_on;

  always_comb begin
    pen_term = pen_reg ? 66'(p3_sd.kpen >>> 16) : '0;
    tsum[0]  = 66'(p3_tp[0] >>> 16) + pen_term;
    tsum[1]  = 66'(p3_tp[1] >>> 16);
    tsum[2]  = 66'(p3_tp[2] >>> 16);
    neg_j[0] = !p3_sd.jn[31];
    neg_j[1] = !p3_sd.js1[31];
    neg_j[2] = !p3_sd.js2[31];
    ts_on    = p3_on && (p3_sm != 47'd0);
  end

  logic [47:0]      o_tn, o_t1, o_t2, o_dss, o_dso, o_dsf;
  logic [DMG_W-1:0] o_dmg;
  logic             o_held;
  logic [31:0]      o_act;
  logic [63:0]      o_tns, o_t1s, o_t2s;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= p3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_tn   <= sat48(tsum[0]);
      o_t1   <= sat48(tsum[1]);
      o_t2   <= sat48(tsum[2]);
      o_dmg  <= p3_dmg;
      o_held <= p3_held;
      o_act  <= p3_act;
      o_dss  <= p3_on ? {1'b0, p3_sm} : 48'd0;
      o_dso  <= p3_on ? (48'd0 - p3_si) : 48'd0;
      o_dsf  <= p3_on ? (48'd0 - p3_sf) : 48'd0;
      o_tns  <= ts_on ? tslope(p3_sp[0], neg_j[0]) : 64'd0;
      o_t1s  <= ts_on ? tslope(p3_sp[1], neg_j[1]) : 64'd0;
      o_t2s  <= ts_on ? tslope(p3_sp[2], neg_j[2]) : 64'd0;
    end
  end

  assign m_tdata = {6'd0, o_t2s, o_t1s, o_tns, o_dsf, o_dso, o_dss,
                    o_act, o_held, o_dmg, o_t2, o_t1, o_tn};

endmodule

FILE: tb/tb_bilinear_cohesive_traction.sv
// Testbench for the bilinear cohesive traction pipeline: directed table plus random stream.
module tb_bilinear_cohesive_traction;
  timeunit 1ns;
  timeprecision 1ps;
  import bct_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_STIFF;
  logic [CFG_W-1:0] cfg_data = '0;

  bilinear_cohesive_traction i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Testbench copy of the configuration registers.
  logic [31:0] stiff_k;
  logic [30:0] onset_sep, fail_sep;
  logic pen_en, jac_en;

  // Expected results in transaction order, plus optional hand-typed checks.
  typedef struct {
    bit en;
    logic [24:0] dmg;
    logic held;
    logic [31:0] act;
  } hand_chk_t;
  logic [OUT_W-1:0] traction_q[$];
  hand_chk_t hand_q[$];
  int errors = 0;
  int snd_idle = 24, rcv_idle = 59;

  // Output field layout, lowest bit up.
  int fld_off[12] = '{0, 48, 96, 144, 169, 170, 202, 250, 298, 346, 410, 474};
  int fld_w[12]   = '{48, 48, 48, 25, 1, 32, 48, 48, 48, 64, 64, 64};

  // floor(n * 2^k / d), capped at lim
  function automatic logic [63:0] qdiv(logic [191:0] n, logic [191:0] d, int k,
                                       logic [63:0] lim);
    logic [191:0] q;
    q = (n << k) / d;
    return (q > 192'(lim)) ? lim : q[63:0];
  endfunction

  function automatic logic [47:0] clip48(longint v);
    if (v > longint'(LIM47)) v = longint'(LIM47);
    if (v < -longint'(LIM47) - 1) v = -longint'(LIM47) - 1;
    return v[47:0];
  endfunction

  // -K * jump * slope, shifted by 16 + SEP_FRAC, saturated to 64 bits
  function automatic logic [63:0] jump_slope(logic [63:0] k, longint jump, logic [63:0] sl);
    logic [63:0] jm, kj, lim;
    logic [191:0] p;
    bit neg;
    jm = (jump < 0) ? 64'(-jump) : 64'(jump);
    kj = k * jm;
    p = (192'(kj) * 192'(sl)) >> TS_SHIFT;
    neg = (jump >= 0);
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (p > 192'(lim)) p = 192'(lim);
    return neg ? -p[63:0] : p[63:0];
  endfunction

  // Predicts the packed result of one material point under the current registers.
  function automatic logic [OUT_W-1:0] predict_traction(logic [IN_W-1:0] d);
    longint dm, jn, pen, js1, js2, di, df, act, tn, t1, t2;
    logic [63:0] dold, trial, dmg, k, sm, si, sf, m, c;
    logic [191:0] den2;
    logic [OUT_W-1:0] r;
    bit grew;
    dm = longint'($signed(d[31:0]));
    jn = longint'($signed(d[63:32]));
    pen = longint'($signed(d[95:64]));
    js1 = longint'($signed(d[127:96]));
    js2 = longint'($signed(d[159:128]));
    dold = 64'(d[184:160]);
    di = longint'(onset_sep);
    df = longint'(fail_sep);
    k = 64'(stiff_k);
    if (dold > 64'(DMG_ONE)) dold = 64'(DMG_ONE);
    if (dm < di) trial = 0;
    else if (dm < df) begin
      if (dm == 0) trial = 0;
      else trial = qdiv(192'(df) * 192'(dm - di), 192'(dm) * 192'(df - di), DMG_FRAC,
                        64'(DMG_ONE));
    end else trial = 64'(DMG_ONE);
    grew = trial > dold;
    dmg = grew ? trial : dold;
    act = longint'((k * (64'(DMG_ONE) - dmg)) >> DMG_FRAC);
    tn = (act * jn) >>> 16;
    if (pen_en) tn += (longint'(k) * pen) >>> 16;
    t1 = (act * js1) >>> 16;
    t2 = (act * js2) >>> 16;
    r = '0;
    r[47:0] = clip48(tn);
    r[95:48] = clip48(t1);
    r[143:96] = clip48(t2);
    r[168:144] = dmg[24:0];
    r[169] = jac_en && !grew;
    r[201:170] = act[31:0];
    if (jac_en && grew && di < dm && dm < df) begin
      m = 64'(dm);
      c = 64'(df - di);
      den2 = 192'(m) * 192'(c * c);
      sm = qdiv(192'(df) * 192'(di), 192'(m * m) * 192'(c), 2 * SEP_FRAC, 64'(LIM47));
      si = qdiv(192'(df) * 192'(df - dm), den2, 2 * SEP_FRAC, 64'(HALF48));
      sf = qdiv(192'(di) * 192'(dm - di), den2, 2 * SEP_FRAC, 64'(HALF48));
      r[249:202] = sm[47:0];
      r[297:250] = -si[47:0];
      r[345:298] = -sf[47:0];
      if (sm != 0) begin
        r[409:346] = jump_slope(k, jn, sm);
        r[473:410] = jump_slope(k, js1, sm);
        r[537:474] = jump_slope(k, js2, sm);
      end
    end
    return r;
  endfunction

  // Receiver: random back-pressure, changed only at rising edges.
  always @(posedge clk) m_tready <= ($urandom_range(99) >= rcv_idle);

  // Result checker; sampled mid-cycle, the transaction completes at the next rising edge.
  always @(negedge clk) begin
    logic [OUT_W-1:0] exp_r;
    hand_chk_t hc;
    logic [63:0] ev, av;
    if (!rst && m_tvalid && m_tready) begin
      if (traction_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        exp_r = traction_q.pop_front();
        hc = hand_q.pop_front();
        for (int f = 0; f < 12; f++) begin
          ev = 64'((exp_r >> fld_off[f]) & ((OUT_W'(1) << fld_w[f]) - 1));
          av = 64'((m_tdata >> fld_off[f]) & ((OUT_W'(1) << fld_w[f]) - 1));
          if (ev !== av) begin
            $display("%0t: field %0d expected %h actual %h", $time, f, ev, av);
            errors++;
          end
        end
        // hand-typed values for the directed rows
        if (hc.en && (m_tdata[168:144] !== hc.dmg || m_tdata[169] !== hc.held ||
                      m_tdata[201:170] !== hc.act)) begin
          $display("%0t: typed check expected %h/%b/%h actual %h/%b/%h", $time, hc.dmg,
                   hc.held, hc.act, m_tdata[168:144], m_tdata[169], m_tdata[201:170]);
          errors++;
        end
      end
    end
  end

  // Called at a rising edge; returns at the edge that accepted the transaction.
  task automatic send_point(logic [IN_W-1:0] d, hand_chk_t hc);
    while ($urandom_range(99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    traction_q.push_back(predict_traction(d));
    hand_q.push_back(hc);
  endtask

  // Drain the pipe, then write all five registers.
  task automatic set_regs(logic [31:0] k, logic [30:0] di, logic [30:0] df, bit pe, bit je);
    s_tvalid <= 1'b0;
    while (traction_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      case (cfg_idx_t'(i))
        CFG_STIFF: cfg_data <= k;
        CFG_ONSET: cfg_data <= 32'(di);
        CFG_FAIL:  cfg_data <= 32'(df);
        CFG_PEN:   cfg_data <= 32'(pe);
        default:   cfg_data <= 32'(je);
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    stiff_k = k;
    onset_sep = di;
    fail_sep = df;
    pen_en = pe;
    jac_en = je;
  endtask

  function automatic logic [IN_W-1:0] pack_point(logic [31:0] dm, logic [31:0] jn,
      logic [31:0] pen, logic [31:0] s1, logic [31:0] s2, logic [24:0] dold);
    return IN_W'({dold, s2, s1, pen, jn, dm});
  endfunction

  // Directed rows under reset registers (K = 1.0, onset 0, failure 1.0, slopes on).
  typedef struct {
    logic [31:0] dm, jn, pen, s1, s2;
    logic [24:0] dold;
    hand_chk_t hc;
  } dir_row_t;
  localparam int NDIR = 12;
  dir_row_t dir_tab[NDIR] = '{
    // zero separation inside the band: no damage, held, full stiffness
    '{32'h0, 32'h100, 32'h0, 32'h0, 32'h0, 25'h0, '{1, 25'h0, 1'b1, 32'h10000}},
    // at or past failure: full damage, no stiffness
    '{32'h0100_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h1, 25'h0,
      '{1, 25'h100_0000, 1'b0, 32'h0}},
    '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 25'h0,
      '{1, 25'h100_0000, 1'b0, 32'h0}},
    // below onset
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 25'h0,
      '{1, 25'h0, 1'b1, 32'h10000}},
    // previous damage at or above one: capped at full damage
    '{32'h0, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 25'h1FF_FFFF,
      '{1, 25'h100_0000, 1'b1, 32'h0}},
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 25'h100_0000, '{1, 25'h100_0000, 1'b1, 32'h0}},
    // inside the band
    '{32'h0080_0000, 32'h0100_0000, 32'h0, 32'hFF00_0000, 32'h0040_0000, 25'h0, '{0, 0, 0, 0}},
    '{32'h0000_0001, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 25'h0, '{0, 0, 0, 0}},
    '{32'h00FF_FFFF, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 25'h80_0000,
      '{0, 0, 0, 0}},
    '{32'h0040_0000, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 25'hFF_FFFF, '{0, 0, 0, 0}},
    '{32'h00C0_0000, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF, 25'h1, '{0, 0, 0, 0}},
    '{32'h00FF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 25'h1FF_FFFF, '{0, 0, 0, 0}}
  };

  // Random point, mostly with the separation near the damage band.
  function automatic logic [IN_W-1:0] rand_point();
    logic [31:0] dm, lo, hi;
    logic [24:0] dold;
    int sel;
    sel = $urandom_range(99);
    lo = 32'(onset_sep);
    hi = 32'(fail_sep);
    if (sel < 70 && hi > lo) dm = lo + ($urandom() % (hi - lo + 1));
    else if (sel < 80) dm = ($urandom_range(1)) ? lo - $urandom_range(3) : hi + $urandom_range(3);
    else dm = $urandom();
    sel = $urandom_range(9);
    if (sel < 6) dold = 25'($urandom_range(32'h100_0000));
    else if (sel < 8) dold = 25'h0;
    else dold = 25'($urandom());
    return pack_point(dm, $urandom(), $urandom(), $urandom(), $urandom(), dold);
  endfunction

  initial begin
    hand_chk_t none;
    none = '{0, 0, 0, 0};
    stiff_k = 32'h10000;
    onset_sep = 31'h0;
    fail_sep = 31'h100_0000;
    pen_en = 1'b0;
    jac_en = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i])
      send_point(pack_point(dir_tab[i].dm, dir_tab[i].jn, dir_tab[i].pen, dir_tab[i].s1,
                            dir_tab[i].s2, dir_tab[i].dold), dir_tab[i].hc);

    // Six register settings; each drains the pipe first, which also pauses the sender.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_regs(32'h0001_8000, 31'h0040_0000, 31'h0100_0000, 1'b1, 1'b1);
        1: set_regs(32'hFFFF_FFFF, 31'h7FFF_FFFE, 31'h7FFF_FFFF, 1'b1, 1'b1);
        2: set_regs(32'h0, 31'h0, 31'h0, 1'b0, 1'b1);
        3: set_regs(32'hFFFF_FFFF, 31'h0000_0001, 31'h7FFF_FFFF, 1'b0, 1'b0);
        4: set_regs(32'h0100_0000, 31'h0300_0000, 31'h0100_0000, 1'b1, 1'b1);
        default: set_regs($urandom(), 31'($urandom_range(32'h0200_0000)),
                          31'($urandom_range(32'h0800_0000, 32'h0200_0001)), 1'b1, 1'b1);
      endcase
      case (p / 2)
        0: begin snd_idle = 24; rcv_idle = 59; end
        1: begin snd_idle = 59; rcv_idle = 24; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      repeat (108) send_point(rand_point(), none);
    end

    s_tvalid <= 1'b0;
    while (traction_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
